[sv/tcw_pkg.sv]
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int CHAR_W = 8;
  localparam int CELL_W = 2 * CHAR_W;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] NULL_CHAR    = 8'h00;
  localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h0F;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

[sv/tcw_grid.sv]
// Cell grid memory: one write port, one read port, registered read data.
`default_nettype none

module tcw_grid #(
  parameter int CELLS  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
  parameter int ADDR_W = $clog2(CELLS)
) (
  input  logic                      clk,
  input  tcw_pkg::mem_ctl_t         ctl,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/tcw_seq.sv]
// Request sequencer: cursor, row base rotation, blanking sweeps and grid access.
`default_nettype none

module tcw_seq #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS,
  parameter int CELLS   = COLUMNS * ROWS,
  parameter int ADDR_W  = $clog2(CELLS),
  parameter int COL_W   = $clog2(COLUMNS),
  parameter int ROW_W   = $clog2(ROWS + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 req_type,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [ADDR_W-1:0]          cell_index,
  input  logic                       cfg_write,
  input  logic [tcw_pkg::CHAR_W-1:0] cfg_data,
  input  logic                       out_free,
  output logic                       res_push,
  output logic [COL_W-1:0]           res_col,
  output logic [ROW_W-1:0]           res_row,
  output logic [tcw_pkg::CHAR_W-1:0] res_char,
  output logic [tcw_pkg::CHAR_W-1:0] res_attr,
  output logic                       res_scroll
);

  localparam int LIN_W = $clog2(CELLS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_BLANK = 5'b00100,
    S_READ  = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_EXEC,
    RET_HOLD
  } ret_t;

  state_t state;
  ret_t   ret;

  logic [tcw_pkg::CHAR_W-1:0] text_attr;
  logic [tcw_pkg::CHAR_W-1:0] blank_attr;
  logic [1:0]                 req;
  logic [tcw_pkg::CHAR_W-1:0] code;
  logic [ADDR_W-1:0]          idx;
  logic [COL_W-1:0]           cur_col;
  logic [ROW_W-1:0]           cur_row;
  logic [LIN_W-1:0]           lin;
  logic [LIN_W-1:0]           base_off;
  logic [LIN_W-1:0]           base_next;
  logic [ADDR_W-1:0]          sweep_addr;
  logic [LIN_W-1:0]           sweep_left;
  logic [tcw_pkg::CHAR_W-1:0] rd_char;
  logic [tcw_pkg::CHAR_W-1:0] rd_attr;
  logic                       scrolled;

  logic is_put;
  logic need_scroll;
  logic idx_ok;
  logic take;

  tcw_pkg::mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]          mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  function automatic logic [ADDR_W-1:0] phys(input logic [LIN_W-1:0] a,
                                             input logic [LIN_W-1:0] base);
    logic [LIN_W:0] s;
    s = {1'b0, a} + {1'b0, base};
    if (s >= (LIN_W+1)'(CELLS)) begin
      s = s - (LIN_W+1)'(CELLS);
    end
    return s[ADDR_W-1:0];
  endfunction

  assign is_put      = (req == tcw_pkg::REQ_PUT) && (code != tcw_pkg::NULL_CHAR);
  assign need_scroll = (cur_row == ROW_W'(ROWS));
  assign idx_ok      = ({1'b0, idx} < (ADDR_W+1)'(CELLS));
  assign base_next   = (base_off + LIN_W'(COLUMNS) >= LIN_W'(CELLS)) ? '0
                       : base_off + LIN_W'(COLUMNS);

  assign take     = (state == S_IDLE) || ((state == S_HOLD) && out_free);
  assign in_stall = rst || !take;
  assign res_push = (state == S_HOLD) && out_free;

  assign res_col    = cur_col;
  assign res_row    = cur_row;
  assign res_char   = rd_char;
  assign res_attr   = rd_attr;
  assign res_scroll = scrolled;

  always_comb begin
    mem_ctl   = '0;
    mem_waddr = sweep_addr;
    mem_wdata = {blank_attr, tcw_pkg::BLANK_CHAR};
    mem_raddr = phys(LIN_W'(idx), base_off);
    if (state == S_BLANK) begin
      mem_ctl.wr_en = 1'b1;
    end else if (state == S_EXEC) begin
      if (is_put && !need_scroll && (code != tcw_pkg::NEWLINE_CHAR)) begin
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = phys(lin, base_off);
        mem_wdata     = {text_attr, code};
      end else if ((req == tcw_pkg::REQ_READ) && idx_ok) begin
        mem_ctl.rd_en = 1'b1;
      end
    end
  end

  tcw_grid #(
    .CELLS  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_grid (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_BLANK;
      ret        <= RET_IDLE;
      sweep_addr <= '0;
      sweep_left <= LIN_W'(CELLS);
      blank_attr <= tcw_pkg::RESET_ATTR;
      text_attr  <= tcw_pkg::RESET_ATTR;
      cur_col    <= '0;
      cur_row    <= '0;
      lin        <= '0;
      base_off   <= '0;
      scrolled   <= 1'b0;
    end else begin
      if (cfg_write) begin
        text_attr <= cfg_data;
      end
      unique case (state)
        S_IDLE, S_HOLD: begin
          if (take && in_valid) begin
            req      <= req_type;
            code     <= char_code;
            idx      <= cell_index;
            rd_char  <= '0;
            rd_attr  <= '0;
            scrolled <= 1'b0;
            state    <= S_EXEC;
          end else if (take) begin
            state <= S_IDLE;
          end
        end
        S_EXEC: begin
          priority if (is_put && need_scroll) begin
            scrolled   <= 1'b1;
            base_off   <= base_next;
            sweep_addr <= base_off[ADDR_W-1:0];
            sweep_left <= LIN_W'(COLUMNS);
            blank_attr <= text_attr;
            cur_col    <= '0;
            cur_row    <= ROW_W'(ROWS - 1);
            lin        <= LIN_W'(CELLS - COLUMNS);
            ret        <= RET_EXEC;
            state      <= S_BLANK;
          end else if (is_put && (code == tcw_pkg::NEWLINE_CHAR)) begin
            cur_col <= '0;
            cur_row <= cur_row + 1'b1;
            lin     <= lin - LIN_W'(cur_col) + LIN_W'(COLUMNS);
            state   <= S_HOLD;
          end else if (is_put) begin
            lin <= lin + 1'b1;
            if (cur_col == COL_W'(COLUMNS - 1)) begin
              cur_col <= '0;
              cur_row <= cur_row + 1'b1;
            end else begin
              cur_col <= cur_col + 1'b1;
            end
            state <= S_HOLD;
          end else if (req == tcw_pkg::REQ_CLEAR) begin
            sweep_addr <= '0;
            sweep_left <= LIN_W'(CELLS);
            blank_attr <= text_attr;
            ret        <= RET_HOLD;
            state      <= S_BLANK;
          end else if ((req == tcw_pkg::REQ_READ) && idx_ok) begin
            state <= S_READ;
          end else begin
            state <= S_HOLD;
          end
        end
        S_BLANK: begin
          sweep_addr <= sweep_addr + 1'b1;
          sweep_left <= sweep_left - 1'b1;
          if (sweep_left == LIN_W'(1)) begin
            unique case (ret)
              RET_IDLE: state <= S_IDLE;
              RET_EXEC: state <= S_EXEC;
              RET_HOLD: state <= S_HOLD;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          rd_char <= mem_rdata[tcw_pkg::CHAR_W-1:0];
          rd_attr <= mem_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
          state   <= S_HOLD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cur_col < COL_W'(COLUMNS))
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    cur_row <= ROW_W'(ROWS))
    else $error("cursor row out of range");

  a_lin_track: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> (int'(lin) == int'(cur_row) * COLUMNS + int'(cur_col)))
    else $error("linear cursor out of step with row and column");

  a_base_range: assert property (@(posedge clk) disable iff (rst)
    base_off < LIN_W'(CELLS))
    else $error("row base offset out of range");

  a_scroll_resume: assert property (@(posedge clk) disable iff (rst)
    (state == S_BLANK && ret == RET_EXEC && sweep_left == LIN_W'(1))
      |=> (state == S_EXEC && cur_row == ROW_W'(ROWS - 1)))
    else $error("put did not resume after scroll blanking");

endmodule

`default_nettype wire

[sv/text_console_writer.sv]
// Top level of the text console writer: sequencer and output register.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------------
//  in       | in_valid / in_stall     | req_type, char_code, cell_index
//  out      | out_valid / out_stall   | cursor_column, cursor_line, read_char,
//           |                         | read_attr, did_scroll
//  cfg      | cfg_write               | cfg_data (text attribute)
//
// Put, read and unknown requests go from the execute state to the hold state; a read
// passes a grid read state in between. A put that scrolls blanks the bottom row, then
// executes again; a clear blanks all cells, one grid write per cycle. Scrolling rotates
// the row base. After reset a blanking pass over all cells runs with in_stall high.
// An item is taken while its predecessor's result is handed to the output register.
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS,
  parameter int ADDR_W  = $clog2(COLUMNS * ROWS),
  parameter int COL_W   = $clog2(COLUMNS),
  parameter int ROW_W   = $clog2(ROWS + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 req_type,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [ADDR_W-1:0]          cell_index,
  input  logic                       cfg_write,
  input  logic [tcw_pkg::CHAR_W-1:0] cfg_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [COL_W-1:0]           cursor_column,
  output logic [ROW_W-1:0]           cursor_line,
  output logic [tcw_pkg::CHAR_W-1:0] read_char,
  output logic [tcw_pkg::CHAR_W-1:0] read_attr,
  output logic                       did_scroll
);

  logic                       out_free;
  logic                       res_push;
  logic [COL_W-1:0]           res_col;
  logic [ROW_W-1:0]           res_row;
  logic [tcw_pkg::CHAR_W-1:0] res_char;
  logic [tcw_pkg::CHAR_W-1:0] res_attr;
  logic                       res_scroll;

  assign out_free = !out_valid || !out_stall;

  tcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .CELLS   (COLUMNS * ROWS),
    .ADDR_W  (ADDR_W),
    .COL_W   (COL_W),
    .ROW_W   (ROW_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .char_code  (char_code),
    .cell_index (cell_index),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .out_free   (out_free),
    .res_push   (res_push),
    .res_col    (res_col),
    .res_row    (res_row),
    .res_char   (res_char),
    .res_attr   (res_attr),
    .res_scroll (res_scroll)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      cursor_column <= res_col;
      cursor_line   <= res_row;
      read_char     <= res_char;
      read_attr     <= res_attr;
      did_scroll    <= res_scroll;
    end
  end

endmodule

`default_nettype wire
